@@ rtl/pdvc_pkg.sv @@
// Shared constants and types for the polygon duplicate vertex cull block.
`timescale 1ns / 1ps
`default_nettype none

package pdvc_pkg;

	// Group buffer geometry
	localparam int MAX_GROUP   = 64;
	localparam int VERTEX_BITS = 32;
	localparam int ADDR_W      = $clog2(MAX_GROUP);
	localparam int CNT_W       = $clog2(MAX_GROUP + 1);

	// Fewest survivors that still leave a polygon, minus one
	localparam int SURVIVE_MIN = 2;

	// Stream field widths
	localparam int VIDX_W      = 32;
	localparam int IN_DATA_W   = ((VIDX_W + 7) / 8) * 8;
	localparam int OUT_FIELD_W = VIDX_W + CNT_W + 3;
	localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

	// Output tdata bit positions
	localparam int OUT_CNT_LSB = VIDX_W;
	localparam int OUT_CHG_BIT = VIDX_W + CNT_W;
	localparam int OUT_KPT_BIT = VIDX_W + CNT_W + 1;
	localparam int OUT_OVF_BIT = VIDX_W + CNT_W + 2;

	typedef enum logic [1:0] {
		ST_COLLECT,
		ST_DECIDE,
		ST_READ,
		ST_CHECK
	} pdvc_state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic wr;
		logic clr;
		logic emit_init;
		logic rd_issue;
		logic advance;
		logic load_vtx;
		logic load_discard;
	} pdvc_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic overflow;
		logic few;
		logic survive;
		logic wrap;
		logic out_free;
	} pdvc_status_t;

endpackage

`default_nettype wire

@@ rtl/pdvc_datapath.sv @@
// Datapath: group store, running survivor count, neighbor compare, result register.
`timescale 1ns / 1ps
`default_nettype none

module pdvc_datapath
	import pdvc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [VIDX_W-1:0]     vertex_in,
	input  wire logic                  end_in,
	input  wire pdvc_cmd_t             cmd,
	output pdvc_status_t               status,
	output logic                       m_tvalid,
	output logic [OUT_DATA_W-1:0]      m_tdata,
	output logic                       m_tuser,
	output logic                       m_tlast,
	input  wire logic                  m_tready
);

	logic [VERTEX_BITS-1:0] mem [MAX_GROUP];

	logic [CNT_W-1:0]       fill_q;
	logic                   ovf_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   chg_q;
	logic [VERTEX_BITS-1:0] first_q;
	logic [VERTEX_BITS-1:0] last_q;
	logic [VERTEX_BITS-1:0] prev_q;
	logic [ADDR_W-1:0]      j_q;
	logic [CNT_W-1:0]       kept_q;
	logic [VERTEX_BITS-1:0] rd_data_s1;
	logic                   wrap_s1;

	logic                   mv_q;
	logic [VERTEX_BITS-1:0] o_vtx_q;
	logic                   o_has_q;
	logic                   o_last_q;
	logic [CNT_W-1:0]       o_cnt_q;
	logic                   o_chg_q;
	logic                   o_kept_q;
	logic                   o_ovf_q;

	logic [VERTEX_BITS-1:0] v;
	logic                   room;
	logic                   is_first;
	logic                   d_prev, e_prev, d_wrap, e_wrap;
	logic [ADDR_W-1:0]      rd_addr;
	logic [VERTEX_BITS-1:0] cur;
	logic                   out_free;

	// Collection: compare each new vertex with its predecessor, and the
	// closing vertex with the first one
	assign v        = vertex_in[VERTEX_BITS-1:0];
	assign room     = fill_q < CNT_W'(MAX_GROUP);
	assign is_first = fill_q == '0;
	assign d_prev   = !is_first && (v != last_q);
	assign e_prev   = !is_first && (v == last_q);
	assign d_wrap   = end_in && !is_first && (v != first_q);
	assign e_wrap   = end_in && (is_first || (v == first_q));

	// Emission: successor comes from the store, or from the first vertex on wrap
	assign rd_addr  = j_q + ADDR_W'(1);
	assign cur      = wrap_s1 ? first_q : rd_data_s1;
	assign out_free = !mv_q || m_tready;

	assign status.overflow = ovf_q;
	assign status.few      = cnt_q <= CNT_W'(SURVIVE_MIN);
	assign status.survive  = prev_q != cur;
	assign status.wrap     = wrap_s1;
	assign status.out_free = out_free;

	// Group store, one write and one registered read port
	always_ff @(posedge clk) begin
		if (cmd.wr && room) begin
			mem[fill_q[ADDR_W-1:0]] <= v;
		end
		if (cmd.rd_issue) begin
			rd_data_s1 <= mem[rd_addr];
			wrap_s1    <= (CNT_W'(j_q) + CNT_W'(1)) == fill_q;
		end
	end

	// Group bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			ovf_q  <= 1'b0;
			cnt_q  <= '0;
			chg_q  <= 1'b0;
		end else if (cmd.clr) begin
			fill_q <= '0;
			ovf_q  <= 1'b0;
			cnt_q  <= '0;
			chg_q  <= 1'b0;
		end else if (cmd.wr) begin
			if (room) begin
				fill_q <= fill_q + CNT_W'(1);
				cnt_q  <= cnt_q + CNT_W'(d_prev) + CNT_W'(d_wrap);
				chg_q  <= chg_q | e_prev | e_wrap;
			end else begin
				ovf_q  <= 1'b1;
			end
		end
	end

	// First and most recent vertex of the group
	always_ff @(posedge clk) begin
		if (cmd.wr && room) begin
			if (is_first) begin
				first_q <= v;
			end
			last_q <= v;
		end
	end

	// Emission walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q    <= '0;
			kept_q <= '0;
		end else if (cmd.emit_init) begin
			j_q    <= '0;
			kept_q <= '0;
		end else if (cmd.advance) begin
			j_q <= j_q + ADDR_W'(1);
			if (cmd.load_vtx) begin
				kept_q <= kept_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_init) begin
			prev_q <= first_q;
		end else if (cmd.advance) begin
			prev_q <= cur;
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mv_q <= 1'b0;
		end else if (cmd.load_vtx || cmd.load_discard) begin
			mv_q <= 1'b1;
		end else if (m_tready) begin
			mv_q <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (cmd.load_vtx) begin
			o_vtx_q  <= prev_q;
			o_has_q  <= 1'b1;
			o_last_q <= (kept_q + CNT_W'(1)) == cnt_q;
			o_cnt_q  <= cnt_q;
			o_chg_q  <= chg_q;
			o_kept_q <= 1'b1;
			o_ovf_q  <= 1'b0;
		end else if (cmd.load_discard) begin
			o_vtx_q  <= '0;
			o_has_q  <= 1'b0;
			o_last_q <= 1'b1;
			o_cnt_q  <= ovf_q ? '0 : cnt_q;
			o_chg_q  <= !ovf_q && chg_q;
			o_kept_q <= 1'b0;
			o_ovf_q  <= ovf_q;
		end
	end

	assign m_tvalid = mv_q;
	assign m_tuser  = o_has_q;
	assign m_tlast  = o_last_q;
	assign m_tdata  = OUT_DATA_W'({o_ovf_q, o_kept_q, o_chg_q, o_cnt_q, VIDX_W'(o_vtx_q)});

endmodule

`default_nettype wire

@@ rtl/pdvc_ctrl.sv @@
// Controller: collect, decide, and read/compare sequencing for one group.
`timescale 1ns / 1ps
`default_nettype none

module pdvc_ctrl
	import pdvc_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	input  wire logic          s_tlast,
	output logic               s_tready,
	input  wire pdvc_status_t  status,
	output pdvc_cmd_t          cmd
);

	pdvc_state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_COLLECT;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_COLLECT: begin
				s_tready = 1'b1;
				cmd.wr   = s_tvalid;
				if (s_tvalid && s_tlast) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (status.overflow || status.few) begin
					if (status.out_free) begin
						cmd.load_discard = 1'b1;
						cmd.clr          = 1'b1;
						state_d          = ST_COLLECT;
					end
				end else begin
					cmd.emit_init = 1'b1;
					state_d       = ST_READ;
				end
			end
			ST_READ: begin
				cmd.rd_issue = 1'b1;
				state_d      = ST_CHECK;
			end
			ST_CHECK: begin
				// a survivor waits for the result register to free up
				if (!status.survive || status.out_free) begin
					cmd.advance  = 1'b1;
					cmd.load_vtx = status.survive;
					if (status.wrap) begin
						cmd.clr = 1'b1;
						state_d = ST_COLLECT;
					end else begin
						state_d = ST_READ;
					end
				end
			end
			default: begin
				state_d = ST_COLLECT;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/polygon_duplicate_vertex_cull.sv @@
// Top level: polygon duplicate vertex cull, stream in and stream out.
// Collection takes one vertex request per cycle until the group end request.
// After group end: a decide state, then for a kept group a store read state
// and a neighbor compare state per stored vertex, plus any stall on the result side.
// A discard or overflow result is loaded into the result register from the decide state once it is free.
// Reset clears the controller, fill count, flags and result valid; store contents are kept.
`timescale 1ns / 1ps
`default_nettype none

module polygon_duplicate_vertex_cull
	import pdvc_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	input  wire logic [IN_DATA_W-1:0]   s_axis_tdata,   // vertex_index
	input  wire logic                   s_axis_tlast,   // group_end
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	// out_vertex, surviving_count, group_changed, group_kept, overflow_error, zero pad
	output logic [OUT_DATA_W-1:0]       m_axis_tdata,
	output logic                        m_axis_tuser,   // has_vertex
	output logic                        m_axis_tlast    // last_of_group
);

	pdvc_cmd_t    cmd;
	pdvc_status_t status;

	pdvc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_axis_tvalid),
		.s_tlast  (s_axis_tlast),
		.s_tready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	pdvc_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.vertex_in (s_axis_tdata[VIDX_W-1:0]),
		.end_in    (s_axis_tlast),
		.cmd       (cmd),
		.status    (status),
		.m_tvalid  (m_axis_tvalid),
		.m_tdata   (m_axis_tdata),
		.m_tuser   (m_axis_tuser),
		.m_tlast   (m_axis_tlast),
		.m_tready  (m_axis_tready)
	);

endmodule

`default_nettype wire

@@ rtl/pdvc_checker.sv @@
// Port-level checks for the cull block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module pdvc_checker
	import pdvc_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  s_axis_tvalid,
	input wire logic                  s_axis_tready,
	input wire logic                  s_axis_tlast,
	input wire logic                  m_axis_tvalid,
	input wire logic                  m_axis_tready,
	input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
	input wire logic                  m_axis_tuser,
	input wire logic                  m_axis_tlast
);

	logic [CNT_W-1:0] cnt;
	assign cnt = m_axis_tdata[OUT_CNT_LSB +: CNT_W];

	// The group end request closes the input until the group is resolved
	a_end_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
		else $error("input ready right after group end");

	// A discard result is always the only and last result of its group
	a_discard_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && !m_axis_tdata[OUT_KPT_BIT])
		else $error("discard result not last or marked kept");

	// An overflow result carries no count, change or keep
	a_overflow_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[OUT_OVF_BIT] |->
			!m_axis_tuser && cnt == '0 && !m_axis_tdata[OUT_CHG_BIT])
		else $error("overflow result with payload");

	// A vertex result belongs to a kept group of at least three survivors
	a_vertex_kept: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |->
			m_axis_tdata[OUT_KPT_BIT] && !m_axis_tdata[OUT_OVF_BIT]
			&& cnt > CNT_W'(SURVIVE_MIN))
		else $error("vertex result from a discarded group");

endmodule

bind polygon_duplicate_vertex_cull pdvc_checker u_pdvc_checker (.*);

`default_nettype wire
